>>> rtl/core/sha_pkg.sv
// ---------------------------------------------------------------------------
// sha_pkg
// Shared constants and the rotate function for the SHA-256 byte stream hash unit.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  // front to back command: one block ready for compression
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_cmd_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned r);
    ror = (x >> r) | (x << (32 - r));
  endfunction

endpackage

>>> rtl/core/sha_front.sv
// ---------------------------------------------------------------------------
// sha_front
// Collects message bytes into blocks, adds padding and length, hands blocks on.
// ---------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              byte_present,
  input  logic              message_end,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sha_pkg::blk_cmd_t cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StPad2 = 2'd2;

  localparam logic [5:0] LenPosC = sha_pkg::LenPos;

  logic [1:0]   state;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bit_len;
  logic         pend;
  logic         pend_final;
  logic [511:0] pend_blk;

  // a pending block must drain before more input is taken
  assign in_ready  = (state == StIdle) && !pend;
  assign cmd_valid = pend;
  assign cmd.block = pend_blk;
  assign cmd.final_blk = pend_final;

  // byte slot writer: byte n sits at bits [511-8n -: 8]
  function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] idx,
                                       input logic [7:0] v);
    logic [511:0] r;
    r = b;
    r[511 - 8*idx -: 8] = v;
    put = r;
  endfunction

  // zero bytes from idx onward
  function automatic logic [511:0] clear_from(input logic [511:0] b, input logic [5:0] idx);
    logic [511:0] m;
    m = {512{1'b1}} << (10'd512 - {idx, 3'b000});
    if (idx == 6'd0) m = '0;
    clear_from = b & m;
  endfunction

  logic [511:0] blk_b;
  logic [5:0]   fill_b;
  logic         full_b;
  logic [511:0] pad_blk;
  logic [511:0] pad_clr;

  // next block contents for a byte beat and for the pad marker
  always_comb begin
    blk_b   = put(blk, fill, data_byte);
    fill_b  = fill + 6'd1;
    full_b  = (fill == 6'd63);
    pad_blk = put(blk, fill, sha_pkg::PadByte);
    pad_clr = (fill == 6'd63) ? pad_blk : clear_from(pad_blk, fill + 6'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= StIdle;
      fill    <= '0;
      bit_len <= '0;
      pend    <= 1'b0;
    end else begin
      if (pend && cmd_ready) pend <= 1'b0;
      case (state)
        StIdle: begin
          if (in_valid && in_ready) begin
            if (byte_present) begin
              blk     <= blk_b;
              fill    <= fill_b;
              bit_len <= bit_len + 64'd8;
              if (full_b) begin
                pend       <= 1'b1;
                pend_blk   <= blk_b;
                pend_final <= 1'b0;
              end
            end
            if (message_end) state <= StPad;
          end
        end
        StPad: begin
          if (!pend) begin
            // pad marker, then either finish here or spill to an extra block
            if (fill < LenPosC) begin
              pend       <= 1'b1;
              pend_final <= 1'b1;
              pend_blk   <= {pad_clr[511:64], bit_len};
              state      <= StIdle;
              fill       <= '0;
              bit_len    <= '0;
            end else begin
              pend       <= 1'b1;
              pend_final <= 1'b0;
              pend_blk   <= pad_clr;
              state      <= StPad2;
            end
          end
        end
        StPad2: begin
          if (!pend) begin
            pend       <= 1'b1;
            pend_final <= 1'b1;
            pend_blk   <= {448'd0, bit_len};
            state      <= StIdle;
            fill       <= '0;
            bit_len    <= '0;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/core/sha_queue.sv
// ---------------------------------------------------------------------------
// sha_queue
// Short block queue between the byte front and the compression back.
// ---------------------------------------------------------------------------
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sha_pkg::blk_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha_pkg::blk_cmd_t rd_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::blk_cmd_t mem [Depth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // storage write
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

  // pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + AW'(1);
      if (do_rd) rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

>>> rtl/core/sha_back.sv
// ---------------------------------------------------------------------------
// sha_back
// Runs the 64-round compression, one round per cycle, and emits the digest.
// ---------------------------------------------------------------------------
module sha_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sha_pkg::blk_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        is_final;
  logic [2:0]  oidx;

  logic [31:0] s0, s1, t1, t2, wn, ch, mj, e0, e1;

  assign cmd_ready   = (state == StIdle);
  assign out_valid   = (state == StOut);
  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // one round and the next schedule word
  always_comb begin
    s0 = sha_pkg::ror(w[1], 7) ^ sha_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::ror(w[14], 17) ^ sha_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    e1 = sha_pkg::ror(v[4], 6) ^ sha_pkg::ror(v[4], 11) ^ sha_pkg::ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + e1 + ch + sha_pkg::RoundK[rnd] + w[0];
    e0 = sha_pkg::ror(v[0], 2) ^ sha_pkg::ror(v[0], 13) ^ sha_pkg::ror(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = e0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rnd   <= '0;
      oidx  <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::InitHash[i];
    end else begin
      case (state)
        StIdle: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= cmd.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            is_final <= cmd.final_blk;
            rnd      <= '0;
            state    <= StRun;
          end
        end
        StRun: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wn;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          oidx  <= '0;
          state <= is_final ? StOut : StIdle;
        end
        StOut: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= sha_pkg::InitHash[i];
              state <= StIdle;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/core/sha256_byte_stream_hash_unit.sv
// ---------------------------------------------------------------------------
// sha256_byte_stream_hash_unit
// SHA-256 over a byte stream with padding and eight-word digest output.
// ---------------------------------------------------------------------------
// channel  dir  tdata                          tuser         tlast
// s_axis   in   [7:0] data_byte                byte_present  message_end
// m_axis   out  [31:0] digest_word,[34:32] idx -             last_word
//
// one beat per cycle while bytes fill a block; the 64th byte holds input off while
// the hand-off register passes the block to the queue.
// in the back a block goes through take, 64 rounds at one per cycle, and add.
// message end adds one or two padding blocks, each waiting for a queue slot,
// then eight output beats; a full queue stalls the front until the back drains.
// rst is synchronous and restores the standard initial hash.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hash_unit #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);

  sha_pkg::blk_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [31:0] dw;
  logic [2:0]  wi;

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .byte_present(s_axis_tuser), .message_end(s_axis_tlast),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  sha_back u_back (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word(dw), .word_index(wi), .last_word(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, wi, dw};

endmodule
